/* rtl/clcp_pkg.sv */
// Shared types and constants of the command-line character parser.
package clcp_pkg;

  localparam int unsigned MaxArgCount = 6;
  localparam int unsigned ArgIdxW     = 3;
  localparam int unsigned ArgW        = 16;
  localparam int unsigned AccW        = 32;
  localparam int unsigned InDataW     = 24;
  localparam int unsigned OutDataW    = 88;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = 1;
  localparam int unsigned QueueCntW   = 2;

  localparam logic [2:0] KIND_ECHO   = 3'd0;
  localparam logic [2:0] KIND_ISSUE  = 3'd1;
  localparam logic [2:0] KIND_USAGE  = 3'd2;
  localparam logic [2:0] KIND_OK     = 3'd3;
  localparam logic [2:0] KIND_ERR    = 3'd4;
  localparam logic [2:0] KIND_REPORT = 3'd5;

  localparam logic [3:0] CMD_CONTRAST  = 4'd0;
  localparam logic [3:0] CMD_INIT      = 4'd1;
  localparam logic [3:0] CMD_DISPLAY   = 4'd2;
  localparam logic [3:0] CMD_LINESTART = 4'd3;
  localparam logic [3:0] CMD_LINE      = 4'd4;
  localparam logic [3:0] CMD_ORIGIN    = 4'd5;
  localparam logic [3:0] CMD_UNITS     = 4'd6;
  localparam logic [3:0] CMD_OUTPUT    = 4'd7;
  localparam logic [3:0] CMD_COUNT     = 4'd8;
  localparam logic [3:0] CMD_VERSION   = 4'd9;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [AccW-1:0] ContrastMask  = 32'h0000_00ff;
  localparam logic [AccW-1:0] LinestartMask = 32'h0000_003F;

  typedef enum logic [4:0] {
    CL_OTHER,
    CL_HASH,
    CL_CR,
    CL_LF,
    CL_DIGIT,
    CL_COMMA,
    CL_REP_COUNT,
    CL_REP_VERSION,
    CL_INIT,
    CL_CONTRAST,
    CL_DISPLAY,
    CL_LINESTART,
    CL_UNITS,
    CL_OUTPUT,
    CL_ORIGIN,
    CL_LINE,
    CL_REPLY
  } class_e;

  typedef struct packed {
    class_e     cls;
    logic [7:0] ch;
    logic       reply_ok;
    logic [7:0] reply_code;
  } entry_t;

  typedef struct packed {
    logic [7:0]         error_code;
    logic               line_inhibit;
    logic [1:0]         line_rop;
    logic [5:0]         line_y2;
    logic [6:0]         line_x2;
    logic [5:0]         line_y1;
    logic [6:0]         line_x1;
    logic signed [31:0] cmd_value;
    logic [3:0]         command;
    logic [7:0]         echo_char;
  } result_t;

endpackage

/* rtl/clcp_front.sv */
// Front end: accepts input items and classifies them for the back end.
module clcp_front (
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [clcp_pkg::InDataW-1:0]     s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output clcp_pkg::entry_t                 push_entry_o
);
  import clcp_pkg::*;

  logic [7:0] ch;

  assign ch              = s_axis_tdata_i[7:0];
  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    push_entry_o            = '0;
    push_entry_o.ch         = ch;
    push_entry_o.reply_ok   = s_axis_tdata_i[8];
    push_entry_o.reply_code = s_axis_tdata_i[16:9];
    if (s_axis_tuser_i) begin
      push_entry_o.cls = CL_REPLY;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      push_entry_o.cls = CL_DIGIT;
    end else begin
      case (ch)
        CHAR_HASH:  push_entry_o.cls = CL_HASH;
        CHAR_CR:    push_entry_o.cls = CL_CR;
        CHAR_LF:    push_entry_o.cls = CL_LF;
        CHAR_COMMA: push_entry_o.cls = CL_COMMA;
        "c":        push_entry_o.cls = CL_REP_COUNT;
        "e":        push_entry_o.cls = CL_REP_VERSION;
        "i":        push_entry_o.cls = CL_INIT;
        "C":        push_entry_o.cls = CL_CONTRAST;
        "j":        push_entry_o.cls = CL_DISPLAY;
        "l":        push_entry_o.cls = CL_LINESTART;
        "u":        push_entry_o.cls = CL_UNITS;
        "z":        push_entry_o.cls = CL_OUTPUT;
        "o":        push_entry_o.cls = CL_ORIGIN;
        "L":        push_entry_o.cls = CL_LINE;
        default:    push_entry_o.cls = CL_OTHER;
      endcase
    end
  end

endmodule

/* rtl/clcp_queue.sv */
// Short queue of classified items between the front end and the back end.
module clcp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clcp_pkg::entry_t  push_entry_i,
  output logic              full_o,
  output logic              valid_o,
  output clcp_pkg::entry_t  head_o,
  input  logic              pop_i
);
  import clcp_pkg::*;

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/clcp_back.sv */
// Back end: parser state, command issue and the registered result stage.
module clcp_back #(
  parameter int unsigned NUM_COLUMNS = 128,
  parameter int unsigned NUM_ROWS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  clcp_pkg::entry_t              q_head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [clcp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [2:0]                    m_axis_tuser_o
);
  import clcp_pkg::*;

  localparam logic [ArgW-1:0] ColLimit = ArgW'(NUM_COLUMNS);
  localparam logic [ArgW-1:0] RowLimit = ArgW'(NUM_ROWS);
  localparam logic [ArgW-1:0] RopLimit = 16'd4;

  logic                busy_q, busy_d;
  logic [3:0]          pend_q, pend_d;
  logic                comment_q, comment_d;
  logic                has_digits_q, has_digits_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [ArgW-1:0]     args_q [MaxArgCount];
  logic [ArgIdxW-1:0]  arg_cnt_q, arg_cnt_d;
  logic                arg_we;
  logic                out_valid_q, out_valid_d;
  logic [2:0]          kind_q, kind_d;
  result_t             res_q, res_d;
  logic                has_res;
  logic                line_ok;
  logic [AccW-1:0]     acc_times10;

  assign pop_o       = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign acc_times10 = (acc_q << 3) + (acc_q << 1);

  always_comb begin
    line_ok = (arg_cnt_q == 3'd5) && has_digits_q &&
              !args_q[0][ArgW-1] && (args_q[0] < ColLimit) &&
              !args_q[1][ArgW-1] && (args_q[1] < RowLimit) &&
              !args_q[2][ArgW-1] && (args_q[2] < ColLimit) &&
              !args_q[3][ArgW-1] && (args_q[3] < RowLimit) &&
              !args_q[4][ArgW-1] && (args_q[4] < RopLimit) &&
              (acc_q[AccW-1:1] == '0);
  end

  always_comb begin
    busy_d       = busy_q;
    pend_d       = pend_q;
    comment_d    = comment_q;
    has_digits_d = has_digits_q;
    acc_d        = acc_q;
    arg_cnt_d    = arg_cnt_q;
    arg_we       = 1'b0;
    has_res      = 1'b0;
    kind_d       = KIND_ECHO;
    res_d        = '0;
    if (q_head_i.cls == CL_REPLY) begin
      if (busy_q) begin
        busy_d        = 1'b0;
        has_res       = 1'b1;
        res_d.command = pend_q;
        if (q_head_i.reply_ok) begin
          kind_d = KIND_OK;
        end else begin
          kind_d           = KIND_ERR;
          res_d.error_code = q_head_i.reply_code;
        end
      end
    end else if (busy_q) begin
      has_res = 1'b0;
    end else if (q_head_i.cls == CL_HASH) begin
      comment_d       = 1'b1;
      has_res         = 1'b1;
      res_d.echo_char = q_head_i.ch;
    end else if (comment_q) begin
      if (q_head_i.cls != CL_CR) begin
        if (q_head_i.cls == CL_LF) begin
          comment_d = 1'b0;
        end
        has_res         = 1'b1;
        res_d.echo_char = q_head_i.ch;
      end
    end else begin
      case (q_head_i.cls)
        CL_DIGIT: begin
          acc_d        = has_digits_q ? acc_times10 + AccW'(q_head_i.ch[3:0])
                                      : AccW'(q_head_i.ch[3:0]);
          has_digits_d = 1'b1;
        end
        CL_REP_COUNT: begin
          has_res       = 1'b1;
          kind_d        = KIND_REPORT;
          res_d.command = CMD_COUNT;
        end
        CL_REP_VERSION: begin
          has_res       = 1'b1;
          kind_d        = KIND_REPORT;
          res_d.command = CMD_VERSION;
        end
        CL_INIT: begin
          has_res       = 1'b1;
          kind_d        = KIND_ISSUE;
          res_d.command = CMD_INIT;
          busy_d        = 1'b1;
          pend_d        = CMD_INIT;
        end
        CL_CONTRAST, CL_DISPLAY, CL_LINESTART, CL_UNITS, CL_OUTPUT: begin
          arg_cnt_d = '0;
          if (has_digits_q) begin
            has_res      = 1'b1;
            kind_d       = KIND_ISSUE;
            busy_d       = 1'b1;
            has_digits_d = 1'b0;
            case (q_head_i.cls)
              CL_CONTRAST: begin
                res_d.command   = CMD_CONTRAST;
                res_d.cmd_value = acc_q & ContrastMask;
              end
              CL_LINESTART: begin
                res_d.command   = CMD_LINESTART;
                res_d.cmd_value = acc_q & LinestartMask;
              end
              CL_DISPLAY: begin
                res_d.command   = CMD_DISPLAY;
                res_d.cmd_value = acc_q;
              end
              CL_UNITS: begin
                res_d.command   = CMD_UNITS;
                res_d.cmd_value = acc_q;
              end
              default: begin
                res_d.command   = CMD_OUTPUT;
                res_d.cmd_value = acc_q;
              end
            endcase
            pend_d = res_d.command;
          end
        end
        CL_ORIGIN: begin
          arg_cnt_d = '0;
          if (has_digits_q) begin
            has_digits_d = 1'b0;
            if (acc_q[AccW-1:2] == '0) begin
              has_res         = 1'b1;
              kind_d          = KIND_ISSUE;
              busy_d          = 1'b1;
              pend_d          = CMD_ORIGIN;
              res_d.command   = CMD_ORIGIN;
              res_d.cmd_value = acc_q;
            end
          end
        end
        CL_LINE: begin
          has_digits_d  = 1'b0;
          arg_cnt_d     = '0;
          has_res       = 1'b1;
          res_d.command = CMD_LINE;
          if (line_ok) begin
            kind_d             = KIND_ISSUE;
            busy_d             = 1'b1;
            pend_d             = CMD_LINE;
            res_d.line_x1      = args_q[0][6:0];
            res_d.line_y1      = args_q[1][5:0];
            res_d.line_x2      = args_q[2][6:0];
            res_d.line_y2      = args_q[3][5:0];
            res_d.line_rop     = args_q[4][1:0];
            res_d.line_inhibit = acc_q[0];
          end else begin
            kind_d = KIND_USAGE;
          end
        end
        CL_COMMA: begin
          if (arg_cnt_q < ArgIdxW'(MaxArgCount)) begin
            arg_we       = 1'b1;
            arg_cnt_d    = arg_cnt_q + 1'b1;
            has_digits_d = 1'b0;
          end
        end
        CL_LF: begin
          has_digits_d = 1'b0;
          arg_cnt_d    = '0;
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = has_res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_q       <= '0;
      comment_q    <= 1'b0;
      has_digits_q <= 1'b0;
      acc_q        <= '0;
      arg_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MaxArgCount; i++) begin
        args_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        busy_q       <= busy_d;
        pend_q       <= pend_d;
        comment_q    <= comment_d;
        has_digits_q <= has_digits_d;
        acc_q        <= acc_d;
        arg_cnt_q    <= arg_cnt_d;
        if (arg_we) begin
          args_q[arg_cnt_q] <= acc_q[ArgW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      kind_q <= kind_d;
      res_q  <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {(OutDataW - $bits(result_t))'(0), res_q};

endmodule

/* rtl/command_line_char_parser_top.sv */
// Top level of the command-line character parser.
//
//   Channel  Direction  Handshake              Payload
//   s_axis   in         tvalid/tready          tdata: char, reply flag, code; tuser: type
//   m_axis   out        tvalid/tready          tdata: result fields; tuser: result kind
//
// One item is taken per cycle while the queue is not full; the back end retires one
// item per cycle while the result register is empty or being read. The front classifies
// an item as it is accepted, the queue registers it and the result register loads it on
// its pop. The two-entry queue keeps the input flowing while the output stalls, until full.
// Reset clears the parser state, the queue and the result valid flag.
module command_line_char_parser_top #(
  parameter int unsigned NUM_COLUMNS = 128,
  parameter int unsigned NUM_ROWS    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] char_byte, [8] reply_ok, [16:9] reply_code
  input  logic [clcp_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] echo_char, [11:8] command, [43:12] cmd_value, [50:44] line_x1,
  // [56:51] line_y1, [63:57] line_x2, [69:64] line_y2, [71:70] line_rop,
  // [72] line_inhibit, [80:73] error_code
  output logic [clcp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [2:0] out_kind
  output logic [2:0]                    m_axis_tuser_o
);
  import clcp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   pop;

  clcp_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_entry_o    (push_entry)
  );

  clcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .head_o       (q_head),
    .pop_i        (pop)
  );

  clcp_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/clcp_checker.sv */
// Port-level checks of the command-line character parser, bound to the top level.
module clcp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [clcp_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [2:0]                    m_axis_tuser_o
);
  import clcp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result item changed or vanished.");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= KIND_REPORT)
    else $error("Result kind out of range.");

  a_echo_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ECHO |-> m_axis_tdata_o[80:8] == '0)
    else $error("Echo item carries command fields.");

  a_report_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_REPORT |->
      m_axis_tdata_o[11:8] == CMD_COUNT || m_axis_tdata_o[11:8] == CMD_VERSION)
    else $error("Report request with a wrong command.");

  a_usage_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_USAGE |->
      m_axis_tdata_o[11:8] == CMD_LINE && m_axis_tdata_o[43:12] == '0)
    else $error("Usage error item with wrong fields.");

endmodule

bind command_line_char_parser_top clcp_checker u_clcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
